FILE: rtl/core/tccs_pkg.sv
// shared constants, types and address helper for the text console core
package tccs_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int WORD_W = 16;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ATTR_W = 7;

    // first cell of the bottom row, end of the scroll copy
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLS;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_BLANK   = 8'h20;
    localparam logic [WORD_W-1:0] CLEAR_WORD = 16'h0720;

    localparam logic [2:0] REQ_PRINT     = 3'd0;
    localparam logic [2:0] REQ_BACKSPACE = 3'd1;
    localparam logic [2:0] REQ_SET_CUR   = 3'd2;
    localparam logic [2:0] REQ_CLEAR     = 3'd3;
    localparam logic [2:0] REQ_PUT_AT    = 3'd4;
    localparam logic [2:0] REQ_READ      = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SCROLL_COPY,
        ST_SCROLL_FILL,
        ST_CLEAR
    } state_t;

    // linear cell index of a row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
    endfunction

endpackage

FILE: rtl/core/tccs_ram.sv
// generic single write port, single read port ram with registered read
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/text_console_cursor_scroll_core.sv
// text console core: cell store, cursor, scroll and clear sequencer
// done is registered, raised the cycle after start; in-range reads hold busy in ST_READ_WAIT
// throughput: one request per cycle while busy is low; done cannot be stalled
// scrolling print: ST_SCROLL_COPY moves rows up, ST_SCROLL_FILL blanks the last row, then done
// clear writes the clear word to every cell, then done
// reset clears cursor, attribute (to 7) and control; the cell store is not cleared
module text_console_cursor_scroll_core (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [7:0]  col,
    input  logic [5:0]  row,
    input  logic [7:0]  cell_color,
    // attribute register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    // result, one beat per request
    output logic        done,
    output logic [6:0]  cursor_col,
    output logic [4:0]  cursor_row,
    output logic [10:0] cursor_pos,
    output logic [15:0] cell_word,
    output logic        scrolled
);

    // control and cursor registers
    tccs_pkg::state_t                   state_reg, state_next;
    logic [tccs_pkg::ADDR_W-1:0]        cnt_reg, cnt_next;
    logic                               copy_vld_reg, copy_vld_next;
    logic [tccs_pkg::ADDR_W-1:0]        copy_addr_reg, copy_addr_next;
    logic [tccs_pkg::COL_W-1:0]         cur_col_reg, cur_col_next;
    logic [tccs_pkg::ROW_W-1:0]         cur_row_reg, cur_row_next;
    logic [tccs_pkg::ATTR_W-1:0]        attr_reg;
    logic                               done_reg, done_next;
    logic [tccs_pkg::WORD_W-1:0]        word_reg, word_next;
    logic                               scrolled_reg, scrolled_next;

    // cell store port
    logic                               ram_we;
    logic [tccs_pkg::ADDR_W-1:0]        ram_waddr;
    logic [tccs_pkg::WORD_W-1:0]        ram_wdata;
    logic [tccs_pkg::ADDR_W-1:0]        ram_raddr;
    logic [tccs_pkg::WORD_W-1:0]        ram_rdata;

    logic                               accept;
    logic                               pos_ok;
    logic [tccs_pkg::ADDR_W-1:0]        req_addr;
    logic [tccs_pkg::ADDR_W-1:0]        cur_addr;
    logic [tccs_pkg::WORD_W-1:0]        blank_word;

    tccs_ram #(
        .WIDTH (tccs_pkg::WORD_W),
        .DEPTH (tccs_pkg::CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy       = (state_reg != tccs_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign cfg_ready  = 1'b1;

    // requested position is in range only inside the visible grid
    assign pos_ok     = (col < 8'(tccs_pkg::COLS)) && (row < 6'(tccs_pkg::ROWS));
    assign req_addr   = tccs_pkg::cell_addr(row[tccs_pkg::ROW_W-1:0],
                                            col[tccs_pkg::COL_W-1:0]);
    assign cur_addr   = tccs_pkg::cell_addr(cur_row_reg, cur_col_reg);
    assign blank_word = {1'b0, attr_reg, tccs_pkg::CHAR_BLANK};

    // result ports: the cursor registers already hold the post-request value
    assign done       = done_reg;
    assign cursor_col = cur_col_reg;
    assign cursor_row = cur_row_reg;
    assign cursor_pos = cur_addr;
    assign cell_word  = word_reg;
    assign scrolled   = scrolled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tccs_pkg::ST_IDLE;
            cnt_reg      <= '0;
            copy_vld_reg <= 1'b0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            attr_reg     <= 7'd7;
            done_reg     <= 1'b0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            copy_vld_reg <= copy_vld_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            done_reg     <= done_next;
            scrolled_reg <= scrolled_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // payload registers need no reset
    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_addr_next;
        word_reg      <= word_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        copy_vld_next  = 1'b0;
        copy_addr_next = copy_addr_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        done_next      = 1'b0;
        word_next      = word_reg;
        scrolled_next  = scrolled_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = blank_word;
        ram_raddr      = req_addr;

        case (state_reg)
            tccs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    word_next     = '0;
                    scrolled_next = 1'b0;
                    done_next     = 1'b1;
                    case (req_type)
                        tccs_pkg::REQ_PRINT:
                        begin
                            if (char_code != tccs_pkg::CHAR_NEWLINE)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = cur_addr;
                                ram_wdata    = {1'b0, attr_reg, char_code};
                            end
                            // advance, wrapping at line end or on newline
                            if ((char_code == tccs_pkg::CHAR_NEWLINE) ||
                                (cur_col_reg == 7'(tccs_pkg::COLS - 1)))
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == 5'(tccs_pkg::ROWS - 1))
                                begin
                                    // past the last row: scroll, cursor stays on last row
                                    scrolled_next = 1'b1;
                                    done_next     = 1'b0;
                                    cnt_next      = '0;
                                    state_next    = tccs_pkg::ST_SCROLL_COPY;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 5'd1;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 7'd1;
                            end
                        end
                        tccs_pkg::REQ_BACKSPACE:
                        begin
                            // nothing happens at column zero
                            if (cur_col_reg != '0)
                            begin
                                cur_col_next = cur_col_reg - 7'd1;
                                ram_we       = 1'b1;
                                ram_waddr    = cur_addr - 11'd1;
                                ram_wdata    = blank_word;
                            end
                        end
                        tccs_pkg::REQ_SET_CUR:
                        begin
                            if (pos_ok)
                            begin
                                cur_col_next = col[tccs_pkg::COL_W-1:0];
                                cur_row_next = row[tccs_pkg::ROW_W-1:0];
                            end
                        end
                        tccs_pkg::REQ_CLEAR:
                        begin
                            done_next    = 1'b0;
                            cnt_next     = '0;
                            cur_col_next = '0;
                            cur_row_next = '0;
                            state_next   = tccs_pkg::ST_CLEAR;
                        end
                        tccs_pkg::REQ_PUT_AT:
                        begin
                            if (pos_ok)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = req_addr;
                                ram_wdata = {cell_color, char_code};
                            end
                        end
                        tccs_pkg::REQ_READ:
                        begin
                            // out of range reads answer zero at once
                            if (pos_ok)
                            begin
                                ram_raddr  = req_addr;
                                done_next  = 1'b0;
                                state_next = tccs_pkg::ST_READ_WAIT;
                            end
                        end
                        default:
                        begin
                            // unused codes: report cursor only
                        end
                    endcase
                end
            end
            tccs_pkg::ST_READ_WAIT:
            begin
                word_next  = ram_rdata;
                done_next  = 1'b1;
                state_next = tccs_pkg::ST_IDLE;
            end
            tccs_pkg::ST_SCROLL_COPY:
            begin
                // read cell cnt+COLS, write it in the next cycle to cell cnt
                ram_we    = copy_vld_reg;
                ram_waddr = copy_addr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = cnt_reg + 11'(tccs_pkg::COLS);
                if (cnt_reg == 11'(tccs_pkg::LAST_ROW_BASE))
                begin
                    // last copy write drains this cycle, fill starts next
                    state_next = tccs_pkg::ST_SCROLL_FILL;
                end
                else
                begin
                    copy_vld_next  = 1'b1;
                    copy_addr_next = cnt_reg;
                    cnt_next       = cnt_reg + 11'd1;
                end
            end
            tccs_pkg::ST_SCROLL_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = blank_word;
                cnt_next  = cnt_reg + 11'd1;
                if (cnt_reg == 11'(tccs_pkg::CELLS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = tccs_pkg::ST_IDLE;
                end
            end
            tccs_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = tccs_pkg::CLEAR_WORD;
                cnt_next  = cnt_reg + 11'd1;
                if (cnt_reg == 11'(tccs_pkg::CELLS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = tccs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tccs_pkg::ST_IDLE;
            end
        endcase
    end

    // cursor never leaves the visible grid
    a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_col_reg < 7'(tccs_pkg::COLS)) && (cur_row_reg < 5'(tccs_pkg::ROWS)))
        else $error("cursor outside grid");

    // a pending copy write only exists while copying
    a_copy_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        copy_vld_reg |-> (state_reg == tccs_pkg::ST_SCROLL_COPY))
        else $error("copy write outside scroll");

    // the read wait cycle leaves the store untouched
    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tccs_pkg::ST_READ_WAIT) |-> !ram_we)
        else $error("write during read wait");

    // an accepted clear holds off further requests
    a_clear_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == tccs_pkg::REQ_CLEAR)) |=> (busy && !done))
        else $error("clear did not start sweep");

endmodule

FILE: verif/text_console_cursor_scroll_core_test.sv
// self-checking testbench for the text console core: cursor, scroll, clear and cell reads
module text_console_cursor_scroll_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // request codes with no operation behind them
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 284;
    // a scroll or a clear sweeps the cell store with no beat, so allow many of those
    localparam int QUIET_LIMIT   = 20000;
    localparam int CYCLE_LIMIT   = 15000000;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic [7:0] c;
        logic [5:0] r;
        logic [7:0] color;
    } console_req_t;

    typedef struct packed {
        logic [6:0]  ccol;
        logic [4:0]  crow;
        logic [10:0] cpos;
        logic [15:0] word;
        logic        scr;
    } cursor_report_t;

    // all block inputs start at known values
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [2:0]  req_type   = '0;
    logic [7:0]  char_code  = '0;
    logic [7:0]  col        = '0;
    logic [5:0]  row        = '0;
    logic [7:0]  cell_color = '0;
    logic        cfg_valid  = 1'b0;
    logic [6:0]  cfg_data   = '0;

    logic        busy;
    logic        cfg_ready;
    logic        done;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_pos;
    logic [15:0] cell_word;
    logic        scrolled;

    // request beats waiting for the driver, reports waiting for the block
    console_req_t   pending_reqs[$];
    cursor_report_t reports_due[$];

    // shadow copy of the console state
    logic [15:0] shadow_cells [tccs_pkg::CELLS];
    int          shadow_col  = 0;
    int          shadow_row  = 0;
    logic [6:0]  shadow_attr = 7'd7;

    int   mismatches  = 0;
    int   cycle_count = 0;
    int   quiet_count = 0;
    int   burst_left  = 8;
    int   gap_left    = 0;
    logic beat_taken  = 1'b0;

    text_console_cursor_scroll_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .char_code  (char_code),
        .col        (col),
        .row        (row),
        .cell_color (cell_color),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cursor_pos (cursor_pos),
        .cell_word  (cell_word),
        .scrolled   (scrolled)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // apply one request to the shadow state and return the report it should give
    function automatic cursor_report_t apply_console_req(console_req_t q);
        cursor_report_t rep;
        int idx;
        logic in_range;
        rep = '0;
        in_range = (int'(q.c) < tccs_pkg::COLS) && (int'(q.r) < tccs_pkg::ROWS);
        case (q.kind)
            tccs_pkg::REQ_PRINT:
            begin
                if (q.ch == tccs_pkg::CHAR_NEWLINE)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                else
                begin
                    shadow_cells[shadow_row * tccs_pkg::COLS + shadow_col] =
                        {1'b0, shadow_attr, q.ch};
                    shadow_col++;
                    // wrap at the line end
                    if (shadow_col >= tccs_pkg::COLS)
                    begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                end
                // past the last row: shift everything up one row, blank the bottom row
                if (shadow_row >= tccs_pkg::ROWS)
                begin
                    for (idx = 0; idx < tccs_pkg::CELLS - tccs_pkg::COLS; idx++)
                        shadow_cells[idx] = shadow_cells[idx + tccs_pkg::COLS];
                    for (idx = tccs_pkg::CELLS - tccs_pkg::COLS; idx < tccs_pkg::CELLS; idx++)
                        shadow_cells[idx] = {1'b0, shadow_attr, tccs_pkg::CHAR_BLANK};
                    shadow_row = tccs_pkg::ROWS - 1;
                    rep.scr = 1'b1;
                end
            end
            tccs_pkg::REQ_BACKSPACE:
            begin
                // nothing happens at column 0
                if (shadow_col > 0)
                begin
                    shadow_col--;
                    shadow_cells[shadow_row * tccs_pkg::COLS + shadow_col] =
                        {1'b0, shadow_attr, tccs_pkg::CHAR_BLANK};
                end
            end
            tccs_pkg::REQ_SET_CUR:
            begin
                if (in_range)
                begin
                    shadow_col = q.c;
                    shadow_row = q.r;
                end
            end
            tccs_pkg::REQ_CLEAR:
            begin
                // clear word ignores the current attribute
                for (idx = 0; idx < tccs_pkg::CELLS; idx++)
                    shadow_cells[idx] = tccs_pkg::CLEAR_WORD;
                shadow_col = 0;
                shadow_row = 0;
            end
            tccs_pkg::REQ_PUT_AT:
            begin
                // explicit color, cursor stays put
                if (in_range)
                    shadow_cells[int'(q.r) * tccs_pkg::COLS + int'(q.c)] = {q.color, q.ch};
            end
            tccs_pkg::REQ_READ:
            begin
                if (in_range)
                    rep.word = shadow_cells[int'(q.r) * tccs_pkg::COLS + int'(q.c)];
            end
            default:
            begin
            end
        endcase
        rep.ccol = 7'(shadow_col);
        rep.crow = 5'(shadow_row);
        rep.cpos = 11'(shadow_row * tccs_pkg::COLS + shadow_col);
        return rep;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d (0x%0h) actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
            mismatches++;
        end
    endfunction

    task automatic add_req(logic [2:0] kind, logic [7:0] ch, logic [7:0] c,
                           logic [5:0] r, logic [7:0] color);
        console_req_t q;
        q.kind  = kind;
        q.ch    = ch;
        q.c     = c;
        q.r     = r;
        q.color = color;
        pending_reqs.push_back(q);
    endtask

    // mostly on screen, leaning toward the bottom rows so scrolls come often
    task automatic pick_pos(output logic [7:0] c, output logic [5:0] r);
        if ($urandom_range(0, 4) == 0)
        begin
            c = 8'($urandom_range(0, 255));
            r = 6'($urandom_range(0, 63));
        end
        else
        begin
            c = 8'($urandom_range(0, tccs_pkg::COLS - 1));
            if ($urandom_range(0, 1) == 0)
                r = 6'($urandom_range(tccs_pkg::ROWS - 3, tccs_pkg::ROWS - 1));
            else
                r = 6'($urandom_range(0, tccs_pkg::ROWS - 1));
        end
    endtask

    task automatic add_random_req();
        logic [7:0] c;
        logic [5:0] r;
        logic [7:0] ch;
        int pick;
        pick = $urandom_range(0, 99);
        c  = 8'($urandom_range(0, 255));
        r  = 6'($urandom_range(0, 63));
        ch = 8'($urandom_range(0, 255));
        if (pick < 52)
        begin
            // about one print in eight is a newline
            if ($urandom_range(0, 7) == 0)
                ch = tccs_pkg::CHAR_NEWLINE;
            add_req(tccs_pkg::REQ_PRINT, ch, c, r, 8'($urandom_range(0, 255)));
        end
        else if (pick < 60)
            add_req(tccs_pkg::REQ_BACKSPACE, ch, c, r, 8'($urandom_range(0, 255)));
        else if (pick < 72)
        begin
            pick_pos(c, r);
            add_req(tccs_pkg::REQ_SET_CUR, ch, c, r, 8'($urandom_range(0, 255)));
        end
        else if (pick < 73)
            add_req(tccs_pkg::REQ_CLEAR, ch, c, r, 8'($urandom_range(0, 255)));
        else if (pick < 82)
        begin
            pick_pos(c, r);
            add_req(tccs_pkg::REQ_PUT_AT, ch, c, r, 8'($urandom_range(0, 255)));
        end
        else if (pick < 97)
        begin
            pick_pos(c, r);
            add_req(tccs_pkg::REQ_READ, ch, c, r, 8'($urandom_range(0, 255)));
        end
        else if (pick < 98)
            add_req(REQ_SPARE_6, ch, c, r, 8'($urandom_range(0, 255)));
        else
            add_req(REQ_SPARE_7, ch, c, r, 8'($urandom_range(0, 255)));
    endtask

    // wait for every queued beat to be taken and every report to come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || start || reports_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_attribute(logic [6:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // request driver: bursts of beats with random gaps, a beat is held until taken
    always @(negedge clk)
    begin : request_driver
        console_req_t q;
        if (!rst_n)
            start <= 1'b0;
        else if (start && !beat_taken)
        begin
            // beat still waiting while the block is busy
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left--;
        end
        else if (pending_reqs.size() > 0)
        begin
            q = pending_reqs.pop_front();
            start      <= 1'b1;
            req_type   <= q.kind;
            char_code  <= q.ch;
            col        <= q.c;
            row        <= q.r;
            cell_color <= q.color;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 24);
                // some bursts follow straight on for long stretches without a gap
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        else
            start <= 1'b0;
    end

    // monitor: checks report beats, predicts taken requests, tracks attribute writes
    always @(posedge clk)
    begin : report_monitor
        cursor_report_t want;
        if (!rst_n)
            beat_taken <= 1'b0;
        else
        begin
            cycle_count++;
            quiet_count++;
            // check the report first: a request taken at this edge cannot answer at it
            if (done)
            begin
                quiet_count = 0;
                if (reports_due.size() == 0)
                begin
                    $display("%0t: report beat expected none actual col %0d row %0d word 0x%0h",
                             $time, cursor_col, cursor_row, cell_word);
                    mismatches++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("cursor_col", want.ccol, cursor_col);
                    check_field("cursor_row", want.crow, cursor_row);
                    check_field("cursor_pos", want.cpos, cursor_pos);
                    check_field("cell_word", want.word, cell_word);
                    check_field("scrolled", want.scr, scrolled);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                shadow_attr = cfg_data;
                quiet_count = 0;
            end
            beat_taken <= start && !busy;
            if (start && !busy)
            begin
                quiet_count = 0;
                reports_due.push_back(apply_console_req({req_type, char_code, col, row,
                                                         cell_color}));
            end
            if (quiet_count > QUIET_LIMIT || cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t: timeout after %0d cycles, %0d reports outstanding",
                         $time, cycle_count, reports_due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        logic [6:0] attr;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset attribute; a clear comes first so every cell is written
        add_req(tccs_pkg::REQ_CLEAR, 8'h00, 8'h00, 6'h00, 8'h00);
        add_req(tccs_pkg::REQ_PRINT, 8'h41, 8'h00, 6'h00, 8'h00);
        add_req(tccs_pkg::REQ_PRINT, 8'h00, 8'h00, 6'h00, 8'h00);
        add_req(tccs_pkg::REQ_PRINT, 8'hff, 8'hff, 6'h3f, 8'hff);
        add_req(tccs_pkg::REQ_PRINT, tccs_pkg::CHAR_NEWLINE, 8'h00, 6'h00, 8'h00);
        // backspace at column 0 changes nothing
        add_req(tccs_pkg::REQ_BACKSPACE, 8'h00, 8'h00, 6'h00, 8'h00);
        add_req(tccs_pkg::REQ_SET_CUR, 8'h00, 8'd3, 6'd0, 8'h00);
        add_req(tccs_pkg::REQ_BACKSPACE, 8'hff, 8'hff, 6'h3f, 8'hff);
        add_req(tccs_pkg::REQ_READ, 8'h00, 8'd2, 6'd0, 8'h00);
        // last cell: print wraps and scrolls
        add_req(tccs_pkg::REQ_SET_CUR, 8'h00, 8'(tccs_pkg::COLS - 1),
                6'(tccs_pkg::ROWS - 1), 8'h00);
        add_req(tccs_pkg::REQ_PRINT, 8'h5a, 8'h00, 6'h00, 8'h00);
        add_req(tccs_pkg::REQ_READ, 8'h00, 8'(tccs_pkg::COLS - 1),
                6'(tccs_pkg::ROWS - 2), 8'h00);
        add_req(tccs_pkg::REQ_READ, 8'h00, 8'd0, 6'(tccs_pkg::ROWS - 1), 8'h00);
        // cursor moves off screen are ignored
        add_req(tccs_pkg::REQ_SET_CUR, 8'h00, 8'(tccs_pkg::COLS), 6'd0, 8'h00);
        add_req(tccs_pkg::REQ_SET_CUR, 8'h00, 8'hff, 6'h3f, 8'h00);
        // put at with explicit color, and off-screen puts ignored
        add_req(tccs_pkg::REQ_PUT_AT, 8'hff, 8'd0, 6'd0, 8'hff);
        add_req(tccs_pkg::REQ_PUT_AT, 8'h33, 8'(tccs_pkg::COLS), 6'd0, 8'h00);
        add_req(tccs_pkg::REQ_PUT_AT, 8'h44, 8'd0, 6'(tccs_pkg::ROWS), 8'h80);
        add_req(tccs_pkg::REQ_READ, 8'h00, 8'd0, 6'd0, 8'h00);
        // off-screen reads give zero
        add_req(tccs_pkg::REQ_READ, 8'h00, 8'(tccs_pkg::COLS), 6'd0, 8'h00);
        add_req(tccs_pkg::REQ_READ, 8'h00, 8'hff, 6'h3f, 8'h00);
        add_req(REQ_SPARE_6, 8'hff, 8'hff, 6'h3f, 8'hff);
        add_req(REQ_SPARE_7, 8'hff, 8'hff, 6'h3f, 8'hff);
        // newline on the bottom row scrolls
        add_req(tccs_pkg::REQ_SET_CUR, 8'h00, 8'd0, 6'(tccs_pkg::ROWS - 1), 8'h00);
        add_req(tccs_pkg::REQ_PRINT, tccs_pkg::CHAR_NEWLINE, 8'h00, 6'h00, 8'h00);
        add_req(tccs_pkg::REQ_CLEAR, 8'hff, 8'hff, 6'h3f, 8'hff);
        wait_drained();

        // random phases, each at its own attribute: both extremes, then random values
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                attr = 7'h7f;
            else if (phase == 1)
                attr = 7'h00;
            else
                attr = 7'($urandom_range(0, 127));
            write_attribute(attr);
            for (int n = 0; n < PHASE_ITEMS; n++)
                add_random_req();
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (reports_due.size() != 0)
            $display("%0t: %0d reports never arrived", $time, reports_due.size());
        if (mismatches == 0 && reports_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
